FILE: hdl/pph_pkg.sv
// ----------------------------------------------------------------------------
// pph_pkg
// Shared constants, register codes, queue entry and state types for the
// particle projection histogram.
// ----------------------------------------------------------------------------
package pph_pkg;

  localparam int GRID   = 256;
  localparam int GRID_W = $clog2(GRID);
  localparam int CELLS  = GRID * GRID;
  localparam int ADDR_W = $clog2(CELLS);

  localparam int POS_W   = 24;
  localparam int SCALE_W = 32;
  localparam int PROD_W  = POS_W + SCALE_W;
  localparam int COUNT_W = 32;
  localparam int CFG_W   = 32;
  localparam int IDX_W   = 3;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  localparam logic [IDX_W-1:0] REG_MIN_X   = 3'd0;
  localparam logic [IDX_W-1:0] REG_MIN_Y   = 3'd1;
  localparam logic [IDX_W-1:0] REG_MIN_Z   = 3'd2;
  localparam logic [IDX_W-1:0] REG_SCALE_X = 3'd3;
  localparam logic [IDX_W-1:0] REG_SCALE_Y = 3'd4;
  localparam logic [IDX_W-1:0] REG_SCALE_Z = 3'd5;

  localparam logic [POS_W-1:0]   MIN_X_RST   = 24'd4523648;
  localparam logic [POS_W-1:0]   MIN_Y_RST   = 24'd9848576;
  localparam logic [POS_W-1:0]   MIN_Z_RST   = 24'd9696128;
  localparam logic [SCALE_W-1:0] SCALE_X_RST = 32'd5419515;
  localparam logic [SCALE_W-1:0] SCALE_Y_RST = 32'd5416098;
  localparam logic [SCALE_W-1:0] SCALE_Z_RST = 32'd5419515;

  localparam logic CMD_BIN  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [1:0] MAP_XY   = 2'd0;
  localparam logic [1:0] MAP_XZ   = 2'd1;
  localparam logic [1:0] MAP_YZ   = 2'd2;
  localparam logic [1:0] MAP_NONE = 2'd3;

  typedef struct packed {
    logic              is_read;
    logic              hit;
    logic [1:0]        map;
    logic [ADDR_W-1:0] addr_xy;
    logic [ADDR_W-1:0] addr_xz;
    logic [ADDR_W-1:0] addr_yz;
  } qentry_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } back_state_t;

endpackage

FILE: hdl/pph_front.sv
// ----------------------------------------------------------------------------
// pph_front
// Holds the box registers, subtracts the box minimum, scales each axis to a
// cell index and classifies each transaction into a queue entry.
// ----------------------------------------------------------------------------
module pph_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic                          command,
  input  logic [pph_pkg::POS_W-1:0]     pos_x,
  input  logic [pph_pkg::POS_W-1:0]     pos_y,
  input  logic [pph_pkg::POS_W-1:0]     pos_z,
  input  logic [1:0]                    read_map,
  input  logic [7:0]                    read_row,
  input  logic [7:0]                    read_col,
  input  logic                          cfg_we,
  input  logic [pph_pkg::IDX_W-1:0]     cfg_index,
  input  logic [pph_pkg::CFG_W-1:0]     cfg_data,
  output logic                          push,
  output pph_pkg::qentry_t              entry,
  output logic [1:0]                    inflight
);

  logic [pph_pkg::POS_W-1:0]   min_x, min_y, min_z;
  logic [pph_pkg::SCALE_W-1:0] scale_x, scale_y, scale_z;

  logic                      s1_valid;
  logic                      s1_cmd;
  logic [pph_pkg::POS_W-1:0] s1_off_x, s1_off_y, s1_off_z;
  logic                      s1_below_x, s1_below_y, s1_below_z;
  logic [1:0]                s1_map;
  logic [7:0]                s1_row, s1_col;

  logic                       s2_valid;
  logic                       s2_cmd;
  logic [pph_pkg::PROD_W-1:0] s2_prod_x, s2_prod_y, s2_prod_z;
  logic                       s2_below_x, s2_below_y, s2_below_z;
  logic [1:0]                 s2_map;
  logic [7:0]                 s2_row, s2_col;

  logic [pph_pkg::POS_W:0]    diff_x, diff_y, diff_z;
  logic [pph_pkg::POS_W-1:0]  idx_x, idx_y, idx_z;
  logic                       keep_x, keep_y, keep_z;
  logic [pph_pkg::GRID_W-1:0] cell_x, cell_y, cell_z;
  logic [pph_pkg::ADDR_W-1:0] read_addr;
  logic                       read_hit;

  function automatic logic [pph_pkg::GRID_W-1:0] clamp_cell(
    input logic [pph_pkg::POS_W-1:0] idx
  );
    if (idx == pph_pkg::POS_W'(pph_pkg::GRID)) begin
      return pph_pkg::GRID_W'(pph_pkg::GRID - 1);
    end
    return idx[pph_pkg::GRID_W-1:0];
  endfunction

  function automatic logic [pph_pkg::ADDR_W-1:0] cell_addr(
    input logic [pph_pkg::GRID_W-1:0] row,
    input logic [pph_pkg::GRID_W-1:0] col
  );
    return pph_pkg::ADDR_W'(row) * pph_pkg::ADDR_W'(pph_pkg::GRID)
         + pph_pkg::ADDR_W'(col);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      min_x   <= pph_pkg::MIN_X_RST;
      min_y   <= pph_pkg::MIN_Y_RST;
      min_z   <= pph_pkg::MIN_Z_RST;
      scale_x <= pph_pkg::SCALE_X_RST;
      scale_y <= pph_pkg::SCALE_Y_RST;
      scale_z <= pph_pkg::SCALE_Z_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pph_pkg::REG_MIN_X:   min_x   <= cfg_data[pph_pkg::POS_W-1:0];
        pph_pkg::REG_MIN_Y:   min_y   <= cfg_data[pph_pkg::POS_W-1:0];
        pph_pkg::REG_MIN_Z:   min_z   <= cfg_data[pph_pkg::POS_W-1:0];
        pph_pkg::REG_SCALE_X: scale_x <= cfg_data[pph_pkg::SCALE_W-1:0];
        pph_pkg::REG_SCALE_Y: scale_y <= cfg_data[pph_pkg::SCALE_W-1:0];
        pph_pkg::REG_SCALE_Z: scale_z <= cfg_data[pph_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  assign diff_x = {1'b0, pos_x} - {1'b0, min_x};
  assign diff_y = {1'b0, pos_y} - {1'b0, min_y};
  assign diff_z = {1'b0, pos_z} - {1'b0, min_z};

  // stage 1: offset from box minimum
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd     <= command;
      s1_off_x   <= diff_x[pph_pkg::POS_W-1:0];
      s1_off_y   <= diff_y[pph_pkg::POS_W-1:0];
      s1_off_z   <= diff_z[pph_pkg::POS_W-1:0];
      s1_below_x <= diff_x[pph_pkg::POS_W];
      s1_below_y <= diff_y[pph_pkg::POS_W];
      s1_below_z <= diff_z[pph_pkg::POS_W];
      s1_map     <= read_map;
      s1_row     <= read_row;
      s1_col     <= read_col;
    end
  end

  // stage 2: scale to cell units
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_cmd     <= s1_cmd;
      s2_prod_x  <= pph_pkg::PROD_W'(s1_off_x) * pph_pkg::PROD_W'(scale_x);
      s2_prod_y  <= pph_pkg::PROD_W'(s1_off_y) * pph_pkg::PROD_W'(scale_y);
      s2_prod_z  <= pph_pkg::PROD_W'(s1_off_z) * pph_pkg::PROD_W'(scale_z);
      s2_below_x <= s1_below_x;
      s2_below_y <= s1_below_y;
      s2_below_z <= s1_below_z;
      s2_map     <= s1_map;
      s2_row     <= s1_row;
      s2_col     <= s1_col;
    end
  end

  // classify
  assign idx_x = s2_prod_x[pph_pkg::PROD_W-1:pph_pkg::SCALE_W];
  assign idx_y = s2_prod_y[pph_pkg::PROD_W-1:pph_pkg::SCALE_W];
  assign idx_z = s2_prod_z[pph_pkg::PROD_W-1:pph_pkg::SCALE_W];

  assign keep_x = !s2_below_x && (idx_x <= pph_pkg::POS_W'(pph_pkg::GRID));
  assign keep_y = !s2_below_y && (idx_y <= pph_pkg::POS_W'(pph_pkg::GRID));
  assign keep_z = !s2_below_z && (idx_z <= pph_pkg::POS_W'(pph_pkg::GRID));

  assign cell_x = clamp_cell(idx_x);
  assign cell_y = clamp_cell(idx_y);
  assign cell_z = clamp_cell(idx_z);

  assign read_hit  = (32'(s2_row) < 32'(pph_pkg::GRID))
                  && (32'(s2_col) < 32'(pph_pkg::GRID))
                  && (s2_map != pph_pkg::MAP_NONE);
  assign read_addr = cell_addr(pph_pkg::GRID_W'(s2_row), pph_pkg::GRID_W'(s2_col));

  always_comb begin
    entry.is_read = (s2_cmd == pph_pkg::CMD_READ);
    entry.map     = s2_map;
    if (s2_cmd == pph_pkg::CMD_READ) begin
      entry.hit     = read_hit;
      entry.addr_xy = read_addr;
      entry.addr_xz = read_addr;
      entry.addr_yz = read_addr;
    end else begin
      entry.hit     = 1'b1;
      entry.addr_xy = cell_addr(cell_x, cell_y);
      entry.addr_xz = cell_addr(cell_x, cell_z);
      entry.addr_yz = cell_addr(cell_y, cell_z);
    end
  end

  assign push = s2_valid
             && ((s2_cmd == pph_pkg::CMD_READ) || (keep_x && keep_y && keep_z));

  assign inflight = {1'b0, s1_valid} + {1'b0, s2_valid};

endmodule

FILE: hdl/pph_queue.sv
// ----------------------------------------------------------------------------
// pph_queue
// Short first-in first-out queue of classified entries between the front
// and back ends.
// ----------------------------------------------------------------------------
module pph_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  pph_pkg::qentry_t            push_entry,
  input  logic                        pop,
  output pph_pkg::qentry_t            head,
  output logic                        empty,
  output logic [pph_pkg::CNT_W-1:0]   count
);

  pph_pkg::qentry_t             store [pph_pkg::QDEPTH];
  logic [pph_pkg::QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic                         full;

  function automatic logic [pph_pkg::QPTR_W-1:0] ptr_inc(
    input logic [pph_pkg::QPTR_W-1:0] p
  );
    if (p == pph_pkg::QPTR_W'(pph_pkg::QDEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign empty = (count == '0);
  assign full  = (count == pph_pkg::CNT_W'(pph_pkg::QDEPTH));
  assign head  = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_entry;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && empty))
    else $error("queue underflow");

endmodule

FILE: hdl/pph_back.sv
// ----------------------------------------------------------------------------
// pph_back
// Owns the three count maps: clears them after reset, then performs a
// read-modify-write per bin transaction and a lookup per read transaction.
// ----------------------------------------------------------------------------
module pph_back (
  input  logic                          clk,
  input  logic                          rst,
  input  pph_pkg::qentry_t              head,
  input  logic                          empty,
  output logic                          pop,
  output logic                          clearing,
  output logic                          done,
  output logic [pph_pkg::COUNT_W-1:0]   cell_count,
  output logic [1:0]                    count_map
);

  logic [pph_pkg::COUNT_W-1:0] xy_mem [pph_pkg::CELLS];
  logic [pph_pkg::COUNT_W-1:0] xz_mem [pph_pkg::CELLS];
  logic [pph_pkg::COUNT_W-1:0] yz_mem [pph_pkg::CELLS];

  pph_pkg::back_state_t        state, state_next;
  pph_pkg::qentry_t            cur;
  logic [pph_pkg::ADDR_W-1:0]  clr_addr;
  logic                        clr_last;
  logic                        upd;
  logic                        mem_we;
  logic [pph_pkg::ADDR_W-1:0]  wa_xy, wa_xz, wa_yz;
  logic [pph_pkg::COUNT_W-1:0] wd_xy, wd_xz, wd_yz;
  logic [pph_pkg::COUNT_W-1:0] rd_xy, rd_xz, rd_yz;
  logic [pph_pkg::COUNT_W-1:0] sel_count;

  function automatic logic [pph_pkg::COUNT_W-1:0] sat_inc(
    input logic [pph_pkg::COUNT_W-1:0] v
  );
    if (v == '1) begin
      return v;
    end
    return v + 1'b1;
  endfunction

  assign clr_last = (clr_addr == pph_pkg::ADDR_W'(pph_pkg::CELLS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pph_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pph_pkg::ST_CLEAR: begin
        if (clr_last) begin
          state_next = pph_pkg::ST_IDLE;
        end
      end
      pph_pkg::ST_IDLE: begin
        if (!empty) begin
          state_next = pph_pkg::ST_UPDATE;
        end
      end
      pph_pkg::ST_UPDATE: begin
        state_next = pph_pkg::ST_IDLE;
      end
      default: begin
        state_next = pph_pkg::ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    clearing = (state == pph_pkg::ST_CLEAR);
    upd      = (state == pph_pkg::ST_UPDATE);
    pop      = (state == pph_pkg::ST_IDLE) && !empty;
    mem_we   = clearing || (upd && !cur.is_read);
    wa_xy    = clearing ? clr_addr : cur.addr_xy;
    wa_xz    = clearing ? clr_addr : cur.addr_xz;
    wa_yz    = clearing ? clr_addr : cur.addr_yz;
    wd_xy    = clearing ? '0 : sat_inc(rd_xy);
    wd_xz    = clearing ? '0 : sat_inc(rd_xz);
    wd_yz    = clearing ? '0 : sat_inc(rd_yz);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      xy_mem[wa_xy] <= wd_xy;
    end
    rd_xy <= xy_mem[head.addr_xy];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      xz_mem[wa_xz] <= wd_xz;
    end
    rd_xz <= xz_mem[head.addr_xz];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      yz_mem[wa_yz] <= wd_yz;
    end
    rd_yz <= yz_mem[head.addr_yz];
  end

  always_comb begin
    sel_count = '0;
    if (cur.hit) begin
      case (cur.map)
        pph_pkg::MAP_XY: sel_count = rd_xy;
        pph_pkg::MAP_XZ: sel_count = rd_xz;
        pph_pkg::MAP_YZ: sel_count = rd_yz;
        default:         sel_count = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= upd && cur.is_read;
    end
  end

  always_ff @(posedge clk) begin
    if (upd && cur.is_read) begin
      cell_count <= sel_count;
      count_map  <= cur.map;
    end
  end

  a_update_after_pop: assert property (@(posedge clk) disable iff (rst)
    (state == pph_pkg::ST_UPDATE) |-> $past(pop))
    else $error("update without a popped entry");

  a_done_from_read: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == pph_pkg::ST_UPDATE && cur.is_read))
    else $error("result strobe without a read transaction");

  a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !pop && !done)
    else $error("transaction handled during clearing pass");

endmodule

FILE: hdl/particle_projection_histogram.sv
// ----------------------------------------------------------------------------
// particle_projection_histogram
// Bins particle positions into xy, xz and yz projection count maps and
// returns single counts on request.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the count maps, one cell
// per cycle over all GRID*GRID cells (65536 at GRID = 256), with busy high.
// After that a transaction is taken whenever start is high and busy is low.
// The front end is a pipeline (offset, scale, classify) feeding a four-entry
// queue; the back end pops each queued transaction in state IDLE, reading the
// count memories, then writes the incremented counts through their single
// write port in state UPDATE, and pops the next one only after that write.
// A read transaction raises done for one cycle with cell_count and count_map,
// after passing the offset and scale registers, the queue, IDLE and UPDATE;
// done cannot be held off. Dropped particles leave no trace.
// ----------------------------------------------------------------------------
module particle_projection_histogram (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          command,
  input  logic [pph_pkg::POS_W-1:0]     pos_x,
  input  logic [pph_pkg::POS_W-1:0]     pos_y,
  input  logic [pph_pkg::POS_W-1:0]     pos_z,
  input  logic [1:0]                    read_map,
  input  logic [7:0]                    read_row,
  input  logic [7:0]                    read_col,
  input  logic                          cfg_we,
  input  logic [pph_pkg::IDX_W-1:0]     cfg_index,
  input  logic [pph_pkg::CFG_W-1:0]     cfg_data,
  output logic                          done,
  output logic [pph_pkg::COUNT_W-1:0]   cell_count,
  output logic [1:0]                    count_map
);

  logic                        accept;
  logic                        push;
  logic                        pop;
  logic                        empty;
  logic                        clearing;
  logic [1:0]                  inflight;
  logic [pph_pkg::CNT_W-1:0]   q_count;
  logic [pph_pkg::CNT_W:0]     pending;
  pph_pkg::qentry_t            push_entry;
  pph_pkg::qentry_t            head;

  // hold off new transactions once every queue slot is spoken for
  assign pending = (pph_pkg::CNT_W + 1)'(q_count) + (pph_pkg::CNT_W + 1)'(inflight);
  assign busy    = clearing || (pending >= (pph_pkg::CNT_W + 1)'(pph_pkg::QDEPTH));
  assign accept  = start && !busy;

  pph_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .command   (command),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pos_z     (pos_z),
    .read_map  (read_map),
    .read_row  (read_row),
    .read_col  (read_col),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .entry     (push_entry),
    .inflight  (inflight)
  );

  pph_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (empty),
    .count      (q_count)
  );

  pph_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .clearing   (clearing),
    .done       (done),
    .cell_count (cell_count),
    .count_map  (count_map)
  );

endmodule
